@@ src/sdap_pkg.sv @@
// ----------------------------------------------------------------------------
// sdap_pkg
// Types and constants shared by the signed decimal ASCII printer modules.
// ----------------------------------------------------------------------------
package sdap_pkg;

   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned CHAR_WIDTH    = 6;
   localparam int unsigned NUM_DIGITS    = 10;
   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned CONV_STEPS    = VALUE_WIDTH / BITS_PER_STEP;
   localparam int unsigned STEP_WIDTH    = $clog2(CONV_STEPS);
   localparam int unsigned INDEX_WIDTH   = $clog2(NUM_DIGITS);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

   typedef logic [3:0] digit_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture magnitude and sign, clear the BCD word
      logic shift;       // one double-dabble step of BITS_PER_STEP bits
      logic set_index;   // point the digit index at the leading digit
      logic emit_sign;   // load a minus sign into the output register
      logic emit_digit;  // load the indexed digit into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic conv_done;   // current shift step is the final one
      logic negative;
      logic last_digit;  // digit index points at the units digit
      logic out_free;    // output register can take a character this cycle
   } status_type;

endpackage

@@ src/sdap_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdap_ctrl
// Sequencer: conversion steps, sign if negative, then digits one per cycle when out_free.
// ----------------------------------------------------------------------------
module sdap_ctrl
   import sdap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!status.negative) begin
               cmd.set_index = 1'b1;
               state_in      = ST_DIGITS;
            end else if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               cmd.set_index = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/sdap_datapath.sv @@
// ----------------------------------------------------------------------------
// sdap_datapath
// Magnitude capture, double-dabble BCD conversion and output register.
// ----------------------------------------------------------------------------
module sdap_datapath
   import sdap_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last
);

   logic [VALUE_WIDTH-1:0]           bin_ff;
   logic [NUM_DIGITS-1:0][3:0]       bcd_ff;
   logic [NUM_DIGITS-1:0][3:0]       bcd_in;
   logic [VALUE_WIDTH-1:0]           bin_in;
   logic                             neg_ff;
   logic [STEP_WIDTH-1:0]            step_ff;
   index_type                        idx_ff;
   index_type                        msd;
   logic                             rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]            rsp_char_code_ff;
   logic                             rsp_last_ff;
   logic                             out_free;

   // Four dabble steps per cycle: correct each digit, then shift one bit in.
   always_comb begin
      logic [NUM_DIGITS-1:0][3:0] b;
      logic [VALUE_WIDTH-1:0]     s;
      b = bcd_ff;
      s = bin_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[d] >= 4'd5) begin
               b[d] = b[d] + 4'd3;
            end
         end
         // drop the top BCD bit, which never holds a one for 32-bit inputs
         b = (NUM_DIGITS*4)'({b, s[VALUE_WIDTH-1]});
         s = {s[VALUE_WIDTH-2:0], 1'b0};
      end
      bcd_in = b;
      bin_in = s;
   end

   // Leading nonzero digit; zero prints as the single units digit.
   always_comb begin
      msd = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d] != 4'd0) begin
            msd = index_type'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= req_value[VALUE_WIDTH-1];
         bin_ff  <= req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
         bcd_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.shift) begin
         bin_ff  <= bin_in;
         bcd_ff  <= bcd_in;
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.set_index) begin
         idx_ff <= msd;
      end else if (cmd.emit_digit) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_char_code_ff <= CHAR_MINUS;
         rsp_last_ff      <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_code_ff <= CHAR_ZERO + {2'b00, bcd_ff[idx_ff]};
         rsp_last_ff      <= (idx_ff == '0);
      end
   end

   assign status.conv_done  = (step_ff == STEP_WIDTH'(CONV_STEPS - 1));
   assign status.negative   = neg_ff;
   assign status.last_digit = (idx_ff == '0);
   assign status.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

   a_emit_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_sign, cmd.emit_digit, cmd.shift, cmd.load}))
      else $error("conflicting datapath commands");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> out_free)
      else $error("character loaded over an untaken one");

   a_units_marks_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && idx_ff == '0) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("units digit not marked last");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_code_ff == CHAR_MINUS ||
                        (rsp_char_code_ff >= CHAR_ZERO &&
                         rsp_char_code_ff <= CHAR_ZERO + 6'd9)))
      else $error("output character is not a digit or minus sign");

endmodule

@@ src/signed_decimal_ascii_printer_top.sv @@
// Operation: a number is taken in ST_IDLE, converted 4 bits per cycle through
// the double-dabble unit in ST_CONVERT, then ST_SIGN loads a minus sign for
// negative values and ST_DIGITS loads the digits, most significant first.
// Throughput is set by the conversion loop and the one-character-per-cycle
// output register, which holds a character until rsp_ready takes it.
// Reset: synchronous, clears the sequencer and the output valid only.
// ----------------------------------------------------------------------------
// signed_decimal_ascii_printer_top
// Prints a signed 32-bit integer as decimal ASCII, most significant first,
// with a leading minus for negative values and a last mark on the final digit.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_printer_top
   import sdap_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input transaction: one integer
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   // result transactions: one character each
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: accepts a transaction only when idle, then steps the
   // conversion and hands out the sign and digits as the output frees up.
   sdap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: magnitude, BCD word, digit index and the output register.
   // The last character may wait in the output register while the next
   // number is already being converted.
   sdap_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

@@ bench/ascii_print_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_print_checker
// Watches both channels of the signed decimal ASCII printer, works out the
// characters each accepted number must produce and compares every character
// transaction against them in order.
// ----------------------------------------------------------------------------
module ascii_print_checker
   import sdap_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [CHAR_WIDTH-1:0]  rsp_char_code,
   input  logic                   rsp_last,
   output int                     mismatch_count,
   output int                     chars_pending
);

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]  code;
      logic                   last;
      logic [VALUE_WIDTH-1:0] number;   // source number, for messages only
   } printed_char_t;

   printed_char_t expected_chars[$];
   printed_char_t want;

   initial begin
      mismatch_count = 0;
      chars_pending  = 0;
   end

   task automatic flag_mismatch(input string detail);
      $display("[%0t] MISMATCH %s", $time, detail);
      mismatch_count++;
   endtask

   // Queue the decimal text of one number: sign first, then digits from the
   // most significant one, last mark on the units digit.
   function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] number);
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
      digit_type              digits[NUM_DIGITS];
      int                     num_digits;
      printed_char_t          ch;
      negative  = number[VALUE_WIDTH-1];
      // the most negative value negates to itself, which read unsigned is right
      magnitude = negative ? (~number + 1'b1) : number;
      num_digits = 0;
      do begin
         digits[num_digits] = digit_type'(magnitude % 10);
         magnitude          = magnitude / 10;
         num_digits++;
      end while (magnitude != 0);
      ch.number = number;
      if (negative) begin
         ch.code = CHAR_MINUS;
         ch.last = 1'b0;
         expected_chars.push_back(ch);
      end
      for (int k = num_digits - 1; k >= 0; k--) begin
         ch.code = CHAR_ZERO + CHAR_WIDTH'(digits[k]);
         ch.last = (k == 0);
         expected_chars.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               flag_mismatch($sformatf("unexpected character code %0d last %0b",
                                       rsp_char_code, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code)
                  flag_mismatch($sformatf("number %0d: char_code %0d, wanted %0d",
                                          $signed(want.number), rsp_char_code, want.code));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("number %0d: last %0b, wanted %0b",
                                          $signed(want.number), rsp_last, want.last));
            end
         end
         if (req_valid && req_ready)
            queue_decimal_text(req_value);
         chars_pending = expected_chars.size();
      end
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives signed 32-bit numbers into the decimal ASCII printer in random
// bursts, stalls the character channel on shifting patterns, and leaves the
// checking to ascii_print_checker before giving the verdict.
// ----------------------------------------------------------------------------
module tb;
   import sdap_pkg::*;

   localparam int NUM_RANDOM   = 400;
   localparam int STALL_LIMIT  = 2000;  // cycles without any transaction
   localparam int DRAIN_CYCLES = 30;    // extra cycles run after the last character

   // receiver stall styles
   localparam int READY_ALWAYS  = 0;
   localparam int READY_COIN    = 1;
   localparam int READY_PATTERN = 2;
   localparam int READY_HOLDS   = 3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_ready = 1'b0;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [CHAR_WIDTH-1:0]  rsp_char_code;
   logic                   rsp_last;
   int                     mismatch_count;
   int                     chars_pending;

   int          burst_left   = 0;
   int          idle_cycles  = 0;
   int unsigned ready_mode   = READY_ALWAYS;
   int unsigned mode_timer   = 0;
   int unsigned hold_timer   = 0;
   logic [7:0]  ready_pattern = 8'hFF;
   logic [2:0]  pattern_pos  = '0;

   // Extremes, sign and digit-count boundaries, the most negative value
   // and alternating bit patterns.
   logic [VALUE_WIDTH-1:0] directed_values[] = '{
      32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
      32'hFFFF_FFF7,  32'd10,         32'hFFFF_FFF6,  32'd99,
      32'd100,        32'hFFFF_FF9C,  32'h7FFF_FFFF,  32'h8000_0000,
      32'h8000_0001,  32'd1000000000, 32'hC465_3600,  32'd999999999,
      32'hC465_3601,  32'd1234567890, 32'hB669_FD2E,  32'h5555_5555,
      32'hAAAA_AAAA,  32'd7
   };

   signed_decimal_ascii_printer_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   ascii_print_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   always #5 clock = ~clock;

   // Receiver: switch stall style at random intervals so that stalls
   // land on the sign slot, the leading digit and the last digit alike.
   always @(posedge clock) begin
      if (mode_timer == 0) begin
         ready_mode    <= $urandom_range(READY_ALWAYS, READY_HOLDS);
         ready_pattern <= 8'($urandom_range(1, 255));
         mode_timer    <= $urandom_range(50, 300);
      end else begin
         mode_timer <= mode_timer - 1;
      end
      pattern_pos <= pattern_pos + 1'b1;
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         READY_PATTERN: begin
            rsp_ready <= ready_pattern[pattern_pos];
         end
         default: begin
            // long holds: flip ready, then keep it until hold_timer runs out
            if (hold_timer == 0) begin
               rsp_ready  <= ~rsp_ready;
               hold_timer <= $urandom_range(0, 30);
            end else begin
               hold_timer <= hold_timer - 1;
            end
         end
      endcase
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Pick a random number: raw words for bit coverage, numbers of a random
   // digit count so that short texts are as common as long ones, and values
   // hugging powers of ten where the digit count changes.
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int unsigned     kind;
      int unsigned     num_digits;
      longint unsigned floor_val;
      longint unsigned ceil_val;
      longint unsigned magnitude;
      longint unsigned limit;
      logic            negative;
      kind     = $urandom_range(0, 9);
      negative = 1'($urandom_range(0, 1));
      if (kind < 3)
         return $urandom;
      num_digits = $urandom_range(1, 10);
      ceil_val   = 1;
      for (int i = 0; i < num_digits; i++)
         ceil_val = ceil_val * 10;
      floor_val = (num_digits == 1) ? 0 : ceil_val / 10;
      if (kind < 8)
         magnitude = floor_val + ({$urandom, $urandom} % (ceil_val - floor_val));
      else
         magnitude = ceil_val / 10 + $urandom_range(0, 2) - 1;
      limit = negative ? 64'd2147483648 : 64'd2147483647;
      if (magnitude > limit)
         magnitude = limit - (magnitude % 1000);
      return negative ? VALUE_WIDTH'(-magnitude) : VALUE_WIDTH'(magnitude);
   endfunction

   // Offer one number and hold it until accepted; at the end of a burst,
   // drop valid for a random gap (sometimes none at all).
   task automatic send_number(input logic [VALUE_WIDTH-1:0] value);
      int unsigned gap;
      req_valid <= 1'b1;
      req_value <= value;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 16);
      foreach (directed_values[i])
         send_number(directed_values[i]);
      repeat (NUM_RANDOM)
         send_number(pick_value());
      req_valid <= 1'b0;
      // advance until every predicted character has come out
      do @(negedge clock); while (chars_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/sdap_pkg.sv
src/sdap_ctrl.sv
src/sdap_datapath.sv
src/signed_decimal_ascii_printer_top.sv
bench/ascii_print_checker.sv
bench/tb.sv
